// ===== sv/tksel_pkg.sv =====
package tksel_pkg;

   localparam int ID_W    = 16;
   localparam int SCORE_W = 32;
   localparam int KEEP_W  = 5;

   localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

   localparam logic REQ_OFFER = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]           id;
      logic signed [SCORE_W-1:0] score;
   } tksel_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_READ,
      ST_UP_EVAL,
      ST_ROOT_EVAL,
      ST_DOWN_READ,
      ST_DOWN_EVAL,
      ST_SCAN,
      ST_SCAN_DRAIN,
      ST_EMIT,
      ST_EMPTY
   } tksel_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_append;
      logic load_replace;
      logic rd_parent;
      logic rd_root;
      logic rd_children;
      logic write_cur;
      logic up_move;
      logic down_move;
      logic flush_start;
      logic scan_rd;
      logic scan_restart;
      logic emit_best;
      logic emit_empty;
      logic clear_fill;
   } tksel_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_flush;
      logic k_zero;
      logic heap_full;
      logic fill_zero;
      logic at_root;
      logic up_stop;
      logic beats_root;
      logic down_stop;
      logic scan_at_end;
      logic emit_final;
      logic out_free;
   } tksel_status_type;

endpackage

// ===== sv/tksel_req_if.sv =====
interface tksel_req_if import tksel_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [ID_W-1:0]           item_id;
   logic signed [SCORE_W-1:0] item_score;

   modport source (output valid, req_type, item_id, item_score, input ready);
   modport sink (input valid, req_type, item_id, item_score, output ready);
endinterface

// ===== sv/tksel_rsp_if.sv =====
interface tksel_rsp_if import tksel_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [ID_W-1:0]           out_id;
   logic signed [SCORE_W-1:0] out_score;
   logic                      is_last;
   logic                      is_empty;

   modport source (output valid, out_id, out_score, is_last, is_empty, input ready);
   modport sink (input valid, out_id, out_score, is_last, is_empty, output ready);
endinterface

// ===== sv/tksel_ctrl.sv =====
module tksel_ctrl import tksel_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tksel_status_type status,
   output tksel_cmd_type    cmd
);

   tksel_state_type state_ff;
   tksel_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.req_flush) begin
                  cmd.flush_start = 1'b1;
                  state_in = status.fill_zero ? ST_EMPTY : ST_SCAN;
               end else if (!status.k_zero) begin
                  if (!status.heap_full) begin
                     cmd.load_append = 1'b1;
                     state_in = ST_UP_READ;
                  end else begin
                     cmd.load_replace = 1'b1;
                     cmd.rd_root      = 1'b1;
                     state_in = ST_ROOT_EVAL;
                  end
               end
            end
         end
         ST_UP_READ: begin
            if (status.at_root) begin
               cmd.write_cur = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in = ST_UP_EVAL;
            end
         end
         ST_UP_EVAL: begin
            if (status.up_stop) begin
               cmd.write_cur = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.up_move = 1'b1;
               state_in = ST_UP_READ;
            end
         end
         ST_ROOT_EVAL: begin
            state_in = status.beats_root ? ST_DOWN_READ : ST_IDLE;
         end
         ST_DOWN_READ: begin
            cmd.rd_children = 1'b1;
            state_in = ST_DOWN_EVAL;
         end
         ST_DOWN_EVAL: begin
            if (status.down_stop) begin
               cmd.write_cur = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.down_move = 1'b1;
               state_in = ST_DOWN_READ;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_at_end) begin
               state_in = ST_SCAN_DRAIN;
            end
         end
         ST_SCAN_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_best = 1'b1;
               if (status.emit_final) begin
                  cmd.clear_fill = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.scan_restart = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_EMPTY: begin
            if (status.out_free) begin
               cmd.emit_empty = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/tksel_datapath.sv =====
module tksel_datapath import tksel_pkg::*; #(
   parameter int TOP_K = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tksel_cmd_type             cmd,
   output tksel_status_type          status,
   input  logic                      csr_wr_en,
   input  logic [KEEP_W-1:0]         csr_wr_data,
   input  logic                      req_type,
   input  logic [ID_W-1:0]           item_id,
   input  logic signed [SCORE_W-1:0] item_score,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [ID_W-1:0]           out_id,
   output logic signed [SCORE_W-1:0] out_score,
   output logic                      is_last,
   output logic                      is_empty
);

   localparam int IDX_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
   localparam int CNT_W = $clog2(TOP_K + 1);
   localparam int KW    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
   localparam int CW    = IDX_W + 2;
   localparam int CMP_W = (CW > KW) ? CW : KW;

   // Heap storage and its registered read ports.
   tksel_entry_type heap_ff [TOP_K];
   tksel_entry_type rd_a_ff;
   tksel_entry_type rd_b_ff;

   logic [KEEP_W-1:0] keep_count_ff;
   logic [CNT_W-1:0]  fill_ff;
   tksel_entry_type   cur_ff;
   logic [IDX_W-1:0]  cur_idx_ff;

   logic [IDX_W-1:0]  scan_idx_ff;
   logic              pend_valid_ff;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic [TOP_K-1:0]  emitted_ff;
   logic              have_best_ff;
   tksel_entry_type   best_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [CNT_W-1:0]  emit_count_ff;

   logic                      rsp_valid_ff;
   logic [ID_W-1:0]           out_id_ff;
   logic signed [SCORE_W-1:0] out_score_ff;
   logic                      is_last_ff;
   logic                      is_empty_ff;

   logic [KW-1:0]            eff_k;
   logic [IDX_W-1:0]         parent_idx;
   logic [CW-1:0]            left_idx;
   logic [CW-1:0]            right_idx;
   logic                     left_ok;
   logic                     right_ok;
   logic                     left_less;
   logic                     right_less;
   logic signed [SCORE_W-1:0] min_score;
   logic [IDX_W-1:0]         rd_a_addr;
   logic [IDX_W-1:0]         rd_b_addr;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   tksel_entry_type          mem_wdata;
   logic                     take_cand;
   logic                     emit_final;
   logic                     out_free;

   assign eff_k = (KW'(keep_count_ff) > KW'(TOP_K)) ? KW'(TOP_K) : KW'(keep_count_ff);

   assign parent_idx = (cur_idx_ff - 1'b1) >> 1;
   assign left_idx   = {1'b0, cur_idx_ff, 1'b1};
   assign right_idx  = left_idx + 1'b1;
   assign left_ok    = CMP_W'(left_idx) < CMP_W'(eff_k);
   assign right_ok   = CMP_W'(right_idx) < CMP_W'(eff_k);

   // The smaller child wins; the left child keeps a tie.
   assign left_less  = left_ok && (rd_a_ff.score < cur_ff.score);
   assign min_score  = left_less ? rd_a_ff.score : cur_ff.score;
   assign right_less = right_ok && (rd_b_ff.score < min_score);

   always_comb begin
      if (cmd.rd_parent) begin
         rd_a_addr = parent_idx;
      end else if (cmd.rd_root) begin
         rd_a_addr = '0;
      end else if (cmd.rd_children) begin
         rd_a_addr = left_idx[IDX_W-1:0];
      end else begin
         rd_a_addr = scan_idx_ff;
      end
   end
   assign rd_b_addr = right_idx[IDX_W-1:0];

   always_comb begin
      mem_we    = cmd.write_cur || cmd.up_move || cmd.down_move;
      mem_waddr = cur_idx_ff;
      if (cmd.up_move) begin
         mem_wdata = rd_a_ff;
      end else if (cmd.down_move) begin
         mem_wdata = right_less ? rd_b_ff : rd_a_ff;
      end else begin
         mem_wdata = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_ff[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= heap_ff[rd_a_addr];
      rd_b_ff <= heap_ff[rd_b_addr];
   end

   // A candidate replaces the best only on a strictly greater score, so
   // equal scores keep the lower array slot first.
   assign take_cand = pend_valid_ff && !emitted_ff[pend_idx_ff] &&
                      (!have_best_ff || (rd_a_ff.score > best_ff.score));
   assign emit_final = (emit_count_ff == fill_ff - 1'b1);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= KEEP_RESET;
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         have_best_ff  <= 1'b0;
         emitted_ff    <= '0;
         emit_count_ff <= '0;
         scan_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            keep_count_ff <= csr_wr_data;
         end
         if (cmd.load_append) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (cmd.clear_fill) begin
            fill_ff <= '0;
         end

         pend_valid_ff <= cmd.scan_rd;
         if (cmd.flush_start || cmd.scan_restart) begin
            scan_idx_ff  <= '0;
            have_best_ff <= 1'b0;
         end else begin
            if (cmd.scan_rd) begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
            if (take_cand) begin
               have_best_ff <= 1'b1;
            end
         end

         if (cmd.flush_start) begin
            emitted_ff    <= '0;
            emit_count_ff <= '0;
         end else if (cmd.emit_best) begin
            emitted_ff[best_idx_ff] <= 1'b1;
            emit_count_ff <= emit_count_ff + 1'b1;
         end

         if (cmd.emit_best || cmd.emit_empty) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_append || cmd.load_replace) begin
         cur_ff.id    <= item_id;
         cur_ff.score <= item_score;
      end
      if (cmd.load_append) begin
         cur_idx_ff <= fill_ff[IDX_W-1:0];
      end else if (cmd.load_replace) begin
         cur_idx_ff <= '0;
      end else if (cmd.up_move) begin
         cur_idx_ff <= parent_idx;
      end else if (cmd.down_move) begin
         cur_idx_ff <= right_less ? rd_b_addr : left_idx[IDX_W-1:0];
      end

      pend_idx_ff <= scan_idx_ff;
      if (take_cand) begin
         best_ff     <= rd_a_ff;
         best_idx_ff <= pend_idx_ff;
      end

      if (cmd.emit_best) begin
         out_id_ff    <= best_ff.id;
         out_score_ff <= best_ff.score;
         is_last_ff   <= emit_final;
         is_empty_ff  <= 1'b0;
      end else if (cmd.emit_empty) begin
         out_id_ff    <= '0;
         out_score_ff <= '0;
         is_last_ff   <= 1'b1;
         is_empty_ff  <= 1'b1;
      end
   end

   always_comb begin
      status.req_flush   = (req_type == REQ_FLUSH);
      status.k_zero      = (eff_k == '0);
      status.heap_full   = (KW'(fill_ff) >= eff_k);
      status.fill_zero   = (fill_ff == '0);
      status.at_root     = (cur_idx_ff == '0);
      status.up_stop     = (rd_a_ff.score <= cur_ff.score);
      status.beats_root  = (cur_ff.score > rd_a_ff.score);
      status.down_stop   = !left_less && !right_less;
      status.scan_at_end = (CNT_W'(scan_idx_ff) == fill_ff - 1'b1);
      status.emit_final  = emit_final;
      status.out_free    = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_id    = out_id_ff;
   assign out_score = out_score_ff;
   assign is_last   = is_last_ff;
   assign is_empty  = is_empty_ff;

endmodule

// ===== sv/top_k_score_selector_core.sv =====
// Channel   Dir   Port      Word
// request   in    req_if    req_type, item_id, item_score
// result    out   rsp_if    out_id, out_score, is_last, is_empty
// config    in    csr_*     keep_count (5 bits), write only
//
// One word is accepted at a time; req_if.ready is high only while the block is idle.
// An append starts at the next free slot and sifts up, comparing with one parent at a
// time until it stops or reaches the root. A replacement that loses to the root is
// dropped; otherwise it takes the root's place and sifts down one level at a time.
// A flush emits the entries highest score first; each emitted word needs a full scan
// through the single scan read port. An empty flush gives one word with is_empty set.
// Reset is synchronous and empties the heap; keep_count returns to 16.
// A stalled result holds in the output register; the flush pauses until it is taken.
module top_k_score_selector_core import tksel_pkg::*; #(
   parameter int TOP_K = 16
) (
   input  logic              clock,
   input  logic              reset,
   tksel_req_if.sink         req_if,
   tksel_rsp_if.source       rsp_if,
   input  logic              csr_wr_en,
   input  logic [KEEP_W-1:0] csr_wr_data
);

   tksel_cmd_type    cmd;
   tksel_status_type status;

   tksel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tksel_datapath #(
      .TOP_K (TOP_K)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_type    (req_if.req_type),
      .item_id     (req_if.item_id),
      .item_score  (req_if.item_score),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .out_id      (rsp_if.out_id),
      .out_score   (rsp_if.out_score),
      .is_last     (rsp_if.is_last),
      .is_empty    (rsp_if.is_empty)
   );

endmodule

// ===== sv/tksel_checker.sv =====
module tksel_checker import tksel_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_type,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [ID_W-1:0]           out_id,
   input logic signed [SCORE_W-1:0] out_score,
   input logic                      is_last,
   input logic                      is_empty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_id) && $stable(out_score) &&
                                  $stable(is_last) && $stable(is_empty))
      else $error("result word changed while stalled");

   // An empty flush gives a single zeroed word that also closes the run.
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_empty |-> is_last && (out_id == '0) && (out_score == '0))
      else $error("empty flush word malformed");

   // A flush always produces at least one word, so the block is busy after it.
   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_FLUSH) |=> !req_ready)
      else $error("request taken right after a flush");

endmodule

bind top_k_score_selector_core tksel_checker u_tksel_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_type  (req_if.req_type),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .out_id    (rsp_if.out_id),
   .out_score (rsp_if.out_score),
   .is_last   (rsp_if.is_last),
   .is_empty  (rsp_if.is_empty)
);
